### rtl/core/ttc_pkg.sv
`timescale 1ns / 1ps

package ttc_pkg;

    localparam int COUNT_W = 19;
    localparam int HOURS_W = 8;
    localparam int MINS_W  = 6;
    localparam int SECS_W  = 6;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    localparam logic [COUNT_W-1:0] SECS_PER_HOUR     = COUNT_W'(3600);
    localparam logic [COUNT_W-1:0] COUNT_LIMIT_RESET = COUNT_W'(360000);
    localparam logic [MINS_W-1:0]  LAST_MINUTE       = MINS_W'(59);
    localparam logic [SECS_W-1:0]  LAST_SECOND       = SECS_W'(59);

    // Trip time held both as a flat second count and as its hour, minute and
    // second digits. The two forms are advanced together so that no division
    // is ever needed to present the digits.
    typedef struct packed {
        logic [COUNT_W-1:0] total;
        logic [HOURS_W-1:0] hh;
        logic [MINS_W-1:0]  mm;
        logic [SECS_W-1:0]  ss;
    } trip_time_t;

    localparam trip_time_t TRIP_TIME_ZERO = '0;

    // Advance a trip time by one second, carrying through the digits.
    function automatic trip_time_t tt_increment(input trip_time_t t);
        trip_time_t r;
        r       = t;
        r.total = t.total + COUNT_W'(1);
        if (t.ss == LAST_SECOND) begin
            r.ss = '0;
            if (t.mm == LAST_MINUTE) begin
                r.mm = '0;
                r.hh = t.hh + HOURS_W'(1);
            end else begin
                r.mm = t.mm + MINS_W'(1);
            end
        end else begin
            r.ss = t.ss + SECS_W'(1);
        end
        return r;
    endfunction

endpackage

### rtl/core/trip_time_counter_core.sv
`timescale 1ns / 1ps

// Channel    | Direction | Beat contents
// -----------+-----------+-----------------------------------------------------
// s_axis     | in        | one-second tick, tdata[0] = ignition_on
// m_axis     | out       | one result per tick: hours, minutes, seconds, valid
// cfg        | in        | count_limit, the trip-second count that wraps to zero
//
// Each tick passes from acceptance into the input register; from there the
// counter update and digit selection feed the result register, which presents
// its result beat. A new tick can be taken every cycle while m_axis accepts
// results; the trip counter needs no divider because the hour, minute and
// second digits are counted alongside the flat count.
// Reset clears the counter, the saved total, the ignition history and both
// pipeline registers, and loads the limit with 360000 seconds.
// When m_axis is stalled, one tick can still wait in the input register.
module trip_time_counter_core (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [0] ignition_on, [7:1] zero
    input  logic [ttc_pkg::S_TDATA_W-1:0] s_axis_tdata,

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] hours, [13:8] minutes, [19:14] seconds, [20] time_valid, [23:21] zero
    output logic [ttc_pkg::M_TDATA_W-1:0] m_axis_tdata,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ttc_pkg::COUNT_W-1:0]   cfg_data
);

    import ttc_pkg::*;

    // Configuration register. Writes are to be made only while the block is idle;
    // the user must keep to this, as the block does not enforce it: it is always ready.
    logic [COUNT_W-1:0] count_limit_reg;

    // Input stage.
    logic in_valid_reg;
    logic in_ign_reg;

    // Counter state.
    trip_time_t running_reg, running_next;
    trip_time_t saved_reg,   saved_next;
    logic       ign_before_reg, ign_before_next;

    // Result stage.
    logic               out_valid_reg;
    logic [HOURS_W-1:0] hours_reg,   hours_next;
    logic [MINS_W-1:0]  minutes_reg, minutes_next;
    logic [SECS_W-1:0]  seconds_reg, seconds_next;
    logic               time_valid_reg, time_valid_next;

    logic       advance;
    trip_time_t base_time;
    trip_time_t incr_time;
    logic       below_hour;
    logic       below_limit;

    // The tick in the input register moves on whenever the result register is
    // empty or its beat is being taken in this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    // When ignition was off on the previous tick, counting resumes from the
    // total saved when it went off.
    assign base_time   = ign_before_reg ? running_reg : saved_reg;
    assign incr_time   = tt_increment(base_time);
    assign below_hour  = incr_time.total < SECS_PER_HOUR;
    assign below_limit = incr_time.total < count_limit_reg;

    always_comb begin
        running_next    = running_reg;
        saved_next      = saved_reg;
        ign_before_next = ign_before_reg;
        hours_next      = '0;
        minutes_next    = '0;
        seconds_next    = '0;
        time_valid_next = 1'b0;
        if (in_ign_reg) begin
            ign_before_next = 1'b1;
            time_valid_next = 1'b1;
            if (below_hour) begin
                // Under one hour the display shows minutes and seconds.
                running_next = incr_time;
                minutes_next = incr_time.mm;
                seconds_next = incr_time.ss;
            end else if (below_limit) begin
                // From one hour up the display shows hours and minutes.
                running_next = incr_time;
                hours_next   = incr_time.hh;
                minutes_next = incr_time.mm;
            end else begin
                // Reaching the limit wraps the trip time back to zero.
                running_next = TRIP_TIME_ZERO;
            end
        end else begin
            // The total is kept only on the falling edge of ignition.
            if (ign_before_reg) begin
                saved_next = running_reg;
            end
            ign_before_next = 1'b0;
            running_next    = TRIP_TIME_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_limit_reg <= COUNT_LIMIT_RESET;
            in_valid_reg    <= 1'b0;
            in_ign_reg      <= 1'b0;
            running_reg     <= TRIP_TIME_ZERO;
            saved_reg       <= TRIP_TIME_ZERO;
            ign_before_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            hours_reg       <= '0;
            minutes_reg     <= '0;
            seconds_reg     <= '0;
            time_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                count_limit_reg <= cfg_data;
            end

            if (s_axis_tvalid && s_axis_tready) begin
                in_valid_reg <= 1'b1;
                in_ign_reg   <= s_axis_tdata[0];
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                running_reg    <= running_next;
                saved_reg      <= saved_next;
                ign_before_reg <= ign_before_next;
                out_valid_reg  <= 1'b1;
                hours_reg      <= hours_next;
                minutes_reg    <= minutes_next;
                seconds_reg    <= seconds_next;
                time_valid_reg <= time_valid_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, time_valid_reg, seconds_reg, minutes_reg, hours_reg};

    // With ignition off on the last tick the running count has been cleared.
    a_off_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !ign_before_reg |-> (running_reg == TRIP_TIME_ZERO))
        else $error("running count not cleared while ignition is off");

    // The digits always describe the flat count.
    a_running_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (running_reg.mm <= LAST_MINUTE) && (running_reg.ss <= LAST_SECOND) &&
        (32'(running_reg.total) == 32'(running_reg.hh) * 32'd3600 +
         32'(running_reg.mm) * 32'd60 + 32'(running_reg.ss)))
        else $error("running digits disagree with running count");

    a_saved_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(saved_reg.total) == 32'(saved_reg.hh) * 32'd3600 +
         32'(saved_reg.mm) * 32'd60 + 32'(saved_reg.ss)))
        else $error("saved digits disagree with saved count");

    // A result for an ignition-off tick carries no time.
    a_off_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !time_valid_reg) |->
        (hours_reg == '0) && (minutes_reg == '0) && (seconds_reg == '0))
        else $error("time shown with ignition off");

endmodule
